// File: hw/rtl/prefix_code_bit_packer_assert.svh
// Assertion macros for the prefix code bit packer.
// Each macro samples on the rising edge of i_clk and is disabled while i_rst_n is low.
`ifndef PREFIX_CODE_BIT_PACKER_ASSERT_SVH
`define PREFIX_CODE_BIT_PACKER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define PCBP_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

`define PCBP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PCBP_ASSERT_ALWAYS(lbl, expr, msg)

`define PCBP_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: hw/rtl/pcbp_pkg.sv
package pcbp_pkg;

    localparam int SYM_W    = 8;
    localparam int CODE_W   = 32;
    localparam int LEN_IN_W = 6;
    localparam int BYTE_W   = 8;
    localparam int CNT_W    = 3;
    // shift buffer: up to seven pending bits ahead of a full-width code
    localparam int BUF_W    = CODE_W + BYTE_W;
    localparam int TOT_W    = 6;

    localparam int DEF_MAX_CODE_LEN  = 32;
    localparam int DEF_ALPHABET_SIZE = 256;

    typedef enum logic [1:0] {
        REQ_WRITE  = 2'd0,
        REQ_ENCODE = 2'd1,
        REQ_FLUSH  = 2'd2
    } t_req_type;

    typedef struct packed {
        t_req_type             req_type;
        logic [SYM_W-1:0]      symbol;
        logic [CODE_W-1:0]     code_bits;
        logic [LEN_IN_W-1:0]   code_len;
    } t_req;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } t_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_EMIT
    } t_state;

endpackage

// File: hw/rtl/pcbp_ram.sv
module pcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/prefix_code_bit_packer.sv
// Encode path: the code RAM is read on the input transfer, ST_LOAD loads the shift buffer
// and ST_EMIT writes the first byte into the output register. An encode, or a flush with pending
// bits, holds off the input until ST_EMIT returns to ST_IDLE; a table write and an empty flush do not.
// The input hold is set by the single-port code RAM with its registered read and the
// byte-wide shift buffer, which gives up one byte per cycle while the output is free.
// Reset (synchronous, active low) clears the pending byte and control; the table is not cleared.

`include "prefix_code_bit_packer_assert.svh"

module prefix_code_bit_packer
    import pcbp_pkg::*;
#(
    parameter int MAX_CODE_LEN  = DEF_MAX_CODE_LEN,
    parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_rsp o_out_data
);

    // stored lengths saturate to the smaller of the field width and the configured maximum
    localparam int CAP     = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam int LEN_W   = $clog2(CAP + 1);
    localparam int ADDR_W  = $clog2(ALPHABET_SIZE);
    localparam int ENTRY_W = CODE_W + LEN_W;

    t_state r_state, n_state;

    logic [BUF_W-1:0]  r_buf, n_buf;
    logic [TOT_W-1:0]  r_total, n_total;
    logic [BYTE_W-1:0] r_pend_byte, n_pend_byte;
    logic [CNT_W-1:0]  r_pend_cnt, n_pend_cnt;
    logic              r_out_valid, n_out_valid;
    t_rsp              r_out, n_out;

    // control decoded from the state
    logic w_in_acc;
    logic w_ram_we;
    logic w_ld_flush;
    logic w_ld_code;
    logic w_emit;
    logic w_close;

    // table write path
    logic [LEN_IN_W-1:0] w_len_sat;
    logic [CODE_W:0]     w_len_one;
    logic [CODE_W-1:0]   w_code_mask;
    logic [ENTRY_W-1:0]  w_wdata;
    logic [ENTRY_W-1:0]  w_rdata;
    logic                w_sym_ok;

    // shift buffer path
    logic [TOT_W-1:0]  w_rd_len;
    logic [TOT_W-1:0]  w_load_total;
    logic [TOT_W-1:0]  w_load_shift;
    logic [TOT_W-1:0]  w_rem;
    logic              w_has_byte;
    logic              w_out_free;
    logic              w_last;

    // ------------------------------------------------------------------
    // Code table: one entry per symbol, length above the masked code.
    // Unwritten entries are never read by a well-formed request stream.
    // ------------------------------------------------------------------
    assign w_len_sat   = (i_in_data.code_len > LEN_IN_W'(CAP)) ? LEN_IN_W'(CAP)
                                                                : i_in_data.code_len;
    assign w_len_one   = (CODE_W + 1)'(1) << w_len_sat;
    // drop any bits above the code length so the buffer merge stays clean
    assign w_code_mask = CODE_W'(w_len_one - (CODE_W + 1)'(1));
    assign w_wdata     = {w_len_sat[LEN_W-1:0], i_in_data.code_bits & w_code_mask};
    assign w_sym_ok    = {1'b0, i_in_data.symbol} < (SYM_W + 1)'(ALPHABET_SIZE);

    pcbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ALPHABET_SIZE)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (i_in_data.symbol[ADDR_W-1:0]),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    // ------------------------------------------------------------------
    // Shift buffer: pending bits sit at the top, the new code right behind
    // them. Each emit takes the top byte and shifts the buffer by one byte.
    // ------------------------------------------------------------------
    assign w_rd_len     = TOT_W'(w_rdata[CODE_W +: LEN_W]);
    assign w_load_total = TOT_W'(r_pend_cnt) + w_rd_len;
    assign w_load_shift = TOT_W'(BUF_W) - w_load_total;

    assign w_has_byte = r_total >= TOT_W'(BYTE_W);
    assign w_rem      = r_total - TOT_W'(BYTE_W);
    assign w_last     = w_rem < TOT_W'(BYTE_W);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_in_acc   = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    case (i_in_data.req_type)
                        REQ_ENCODE: begin
                            if (w_sym_ok) begin
                                n_state = ST_LOAD;
                            end
                        end
                        REQ_FLUSH: begin
                            if (r_pend_cnt != '0) begin
                                n_state = ST_EMIT;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LOAD: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                // leave once the remaining bits fit in the pending byte
                if (!w_has_byte || (w_out_free && w_last)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control outputs of the sequencer
    // ------------------------------------------------------------------
    always_comb begin
        o_in_ready = 1'b0;
        w_ram_we   = 1'b0;
        w_ld_flush = 1'b0;
        w_ld_code  = 1'b0;
        w_emit     = 1'b0;
        w_close    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                w_ram_we   = w_in_acc && (i_in_data.req_type == REQ_WRITE) && w_sym_ok;
                w_ld_flush = w_in_acc && (i_in_data.req_type == REQ_FLUSH)
                             && (r_pend_cnt != '0);
            end
            ST_LOAD: begin
                w_ld_code = 1'b1;
            end
            ST_EMIT: begin
                w_emit  = w_has_byte && w_out_free;
                w_close = !w_has_byte;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------
    always_comb begin
        n_buf       = r_buf;
        n_total     = r_total;
        n_pend_byte = r_pend_byte;
        n_pend_cnt  = r_pend_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        if (w_ld_flush) begin
            // a flush is a single padded byte
            n_buf   = {r_pend_byte, CODE_W'(0)};
            n_total = TOT_W'(BYTE_W);
        end

        if (w_ld_code) begin
            n_buf   = {r_pend_byte, CODE_W'(0)}
                      | ({BYTE_W'(0), w_rdata[CODE_W-1:0]} << w_load_shift);
            n_total = w_load_total;
        end

        if (w_emit) begin
            n_out_valid    = 1'b1;
            n_out.out_byte = r_buf[BUF_W-1 -: BYTE_W];
            n_out.last     = w_last;
            n_buf          = r_buf << BYTE_W;
            n_total        = w_rem;
            if (w_last) begin
                // hand the leftover bits back to the pending byte
                n_pend_byte = r_buf[BUF_W-BYTE_W-1 -: BYTE_W];
                n_pend_cnt  = w_rem[CNT_W-1:0];
            end
        end

        if (w_close) begin
            n_pend_byte = r_buf[BUF_W-1 -: BYTE_W];
            n_pend_cnt  = r_total[CNT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_total     <= '0;
            r_pend_byte <= '0;
            r_pend_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_pend_byte <= n_pend_byte;
            r_pend_cnt  <= n_pend_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // the buffer never holds more than seven pending bits plus one full code
    `PCBP_ASSERT_ALWAYS(a_total_range, r_total <= TOT_W'(BUF_W - 1), "bit count overflow")

    // bits beyond the pending count must be zero, or padding would corrupt output
    `PCBP_ASSERT_ALWAYS(a_pend_clean, (r_pend_byte & (8'hFF >> r_pend_cnt)) == '0, "dirty pending")

    // a byte flagged last always returns the sequencer to idle
    `PCBP_ASSERT_NEXT(a_last_idle, w_emit && w_last, r_state == ST_IDLE, "no idle after last byte")

endmodule

// File: bench/tb_packed_byte_check.sv
`timescale 1ns / 100ps

// Watches both channels of the bit packer, predicts the packed bytes of every input
// transfer and checks each output transfer against the oldest byte still owed.
module tb_packed_byte_check
    import pcbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_req i_in_data,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  t_rsp i_out_data,
    output int   o_fail_count,
    output int   o_expect_count
);

    localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

    logic [CODE_W-1:0]   code_table [256];
    logic [LEN_IN_W-1:0] len_table  [256];
    logic [BYTE_W-1:0]   acc_byte = '0;
    int                  acc_bits = 0;
    t_rsp                byte_expect_q [$];
    int                  n_fail = 0;

    task automatic owe_byte(input logic is_last);
        t_rsp rsp;
        rsp.out_byte = acc_byte;
        rsp.last     = is_last;
        byte_expect_q.push_back(rsp);
        acc_byte = '0;
        acc_bits = 0;
    endtask

    task automatic predict_packed_bytes(input t_req req);
        int   code_len;
        int   n_bytes;
        t_rsp rsp;
        n_bytes = 0;
        case (req.req_type)
            REQ_WRITE: begin
                code_len = (int'(req.code_len) > LEN_CAP) ? LEN_CAP : int'(req.code_len);
                code_table[req.symbol] = req.code_bits;
                len_table[req.symbol]  = code_len[LEN_IN_W-1:0];
            end
            REQ_ENCODE: begin
                for (int i = int'(len_table[req.symbol]) - 1; i >= 0; i--) begin
                    acc_byte[BYTE_W - 1 - acc_bits] = code_table[req.symbol][i];
                    acc_bits++;
                    if (acc_bits == BYTE_W) begin
                        owe_byte(1'b0);
                        n_bytes++;
                    end
                end
                if (n_bytes > 0) begin
                    rsp      = byte_expect_q.pop_back();
                    rsp.last = 1'b1;
                    byte_expect_q.push_back(rsp);
                end
            end
            REQ_FLUSH: begin
                if (acc_bits > 0)
                    owe_byte(1'b1);
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        t_rsp want;
        if (!i_rst_n) begin
            acc_byte = '0;
            acc_bits = 0;
            byte_expect_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (byte_expect_q.size() == 0) begin
                    $display("%0t: byte transfer with none owed: expected nothing, actual %02h last %0b",
                             $time, i_out_data.out_byte, i_out_data.last);
                    n_fail++;
                end else begin
                    want = byte_expect_q.pop_front();
                    if (i_out_data.out_byte !== want.out_byte) begin
                        $display("%0t: out_byte: expected %02h, actual %02h",
                                 $time, want.out_byte, i_out_data.out_byte);
                        n_fail++;
                    end
                    if (i_out_data.last !== want.last) begin
                        $display("%0t: last: expected %0b, actual %0b",
                                 $time, want.last, i_out_data.last);
                        n_fail++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                predict_packed_bytes(i_in_data);
        end
        o_fail_count   <= n_fail;
        o_expect_count <= byte_expect_q.size();
    end

endmodule

// File: bench/tb_prefix_code_bit_packer.sv
`timescale 1ns / 100ps

module tb_prefix_code_bit_packer;
    import pcbp_pkg::*;

    localparam int         N_RANDOM_ITEMS  = 405;
    localparam int         IDLE_LIMIT      = 1000;  // cycles without any transfer
    localparam int         HOLD_OFF_AFTER  = 60;    // output transfers before the long stall
    localparam int         HOLD_OFF_CYCLES = 100;
    localparam int         DRAIN_CYCLES    = 8;
    localparam logic [1:0] REQ_UNUSED      = 2'd3;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_ready;
    t_req in_data   = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_rsp out_data;
    int   fail_count;
    int   expect_count;

    // Stimulus bookkeeping: which table entries hold a code, so that an encode
    // never reads an entry that was never written.
    bit              sym_loaded [256];
    logic [SYM_W-1:0] loaded_syms [$];
    int              n_offered = 0;

    prefix_code_bit_packer u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    tb_packed_byte_check u_byte_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_in_data      (in_data),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_out_data     (out_data),
        .o_fail_count   (fail_count),
        .o_expect_count (expect_count)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Offer one request and hold it until the transfer. Valid is only dropped when
    // a gap is drawn, so back-to-back requests keep it high without a glitch.
    // Every 48 requests the first 12 go out with no gaps at all.
    task automatic offer_req(input t_req req);
        int gap;
        gap = ((n_offered % 48) < 12) ? 0 : $urandom_range(0, 3);
        n_offered++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    function automatic t_req make_req(input t_req_type kind, input logic [SYM_W-1:0] sym,
                                      input logic [CODE_W-1:0] bits,
                                      input logic [LEN_IN_W-1:0] len);
        t_req req;
        req.req_type  = kind;
        req.symbol    = sym;
        req.code_bits = bits;
        req.code_len  = len;
        return req;
    endfunction

    task automatic load_code(input logic [SYM_W-1:0] sym, input logic [CODE_W-1:0] bits,
                             input logic [LEN_IN_W-1:0] len);
        offer_req(make_req(REQ_WRITE, sym, bits, len));
        if (!sym_loaded[sym]) begin
            sym_loaded[sym] = 1'b1;
            loaded_syms.push_back(sym);
        end
    endtask

    // Code fields are don't-care for encode and flush; fill them with noise anyway.
    task automatic encode_sym(input logic [SYM_W-1:0] sym);
        offer_req(make_req(REQ_ENCODE, sym, CODE_W'($urandom),
                           LEN_IN_W'($urandom_range(0, 63))));
    endtask

    task automatic flush_bits();
        offer_req(make_req(REQ_FLUSH, SYM_W'($urandom), CODE_W'($urandom),
                           LEN_IN_W'($urandom_range(0, 63))));
    endtask

    task automatic send_unused();
        offer_req(make_req(t_req_type'(REQ_UNUSED), SYM_W'($urandom), CODE_W'($urandom),
                           LEN_IN_W'($urandom_range(0, 63))));
    endtask

    initial begin : stimulus
        int pick;
        int n_counted;
        int len;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: flush with nothing pending first.
        flush_bits();
        load_code(8'h00, 32'hFFFF_FFFF, 6'd32);   // longest code, all ones
        load_code(8'hFF, 32'h0000_0000, 6'd0);    // zero length entry
        load_code(8'h55, 32'h0000_0005, 6'd3);
        load_code(8'hAA, 32'hABCD_1234, 6'd63);   // overlong, saturates to 32
        load_code(8'h01, 32'h0000_0001, 6'd1);
        load_code(8'h03, 32'h8000_0001, 6'd33);   // just above the cap
        load_code(8'h02, 32'hFFFF_FF7F, 6'd7);    // high bits outside the length ignored
        encode_sym(8'h00);                        // four full bytes, nothing left over
        encode_sym(8'hFF);                        // appends nothing
        encode_sym(8'h55);
        flush_bits();                             // padded partial byte
        flush_bits();                             // now empty
        encode_sym(8'h01);
        encode_sym(8'hAA);                        // 33 bits: four bytes, one bit left
        send_unused();
        encode_sym(8'h00);
        encode_sym(8'h03);
        flush_bits();
        encode_sym(8'h02);
        encode_sym(8'h01);                        // completes a byte exactly
        flush_bits();                             // empty again
        load_code(8'hFF, 32'hDEAD_BEEF, 6'd20);   // rewrite an entry
        encode_sym(8'hFF);
        flush_bits();

        // Random part: mostly encodes of loaded symbols, with table writes, flushes
        // and the odd unused request mixed in. Lengths lean short, as real prefix
        // codes do, with some long and some overlong ones.
        n_counted = 0;
        while (n_counted < N_RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                send_unused();
            end else begin
                n_counted++;
                if (pick < 18) begin
                    len = $urandom_range(0, 99);
                    if (len < 75)
                        len = $urandom_range(0, 12);
                    else if (len < 95)
                        len = $urandom_range(13, 32);
                    else
                        len = $urandom_range(33, 63);
                    load_code(SYM_W'($urandom), CODE_W'($urandom), len[LEN_IN_W-1:0]);
                end else if (pick < 88) begin
                    encode_sym(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]);
                end else begin
                    flush_bits();
                end
            end
        end
        flush_bits();
        in_valid <= 1'b0;

        // Let the checker catch up with the last transfer, then drain.
        @(posedge clk);
        while (expect_count != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Receiver: draw a wait before each byte, with stretches of none. Once, hold off
    // for a long while so that the packer fills up and stalls its input.
    initial begin : receiver
        int wait_cycles;
        int n_taken;
        n_taken = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (n_taken == HOLD_OFF_AFTER)
                wait_cycles = HOLD_OFF_CYCLES;
            else if ((n_taken % 40) < 10)
                wait_cycles = 0;
            else
                wait_cycles = $urandom_range(0, 3);
            if (wait_cycles > 0) begin
                out_ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            n_taken++;
        end
    end

    // Watchdog: end the run if nothing moves on either channel for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

endmodule
